### rtl/mfsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfsp_pkg
// Shared types and constants for the motion file byte stream parser.
// ----------------------------------------------------------------------------
package mfsp_pkg;

    // result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_AXIS   = 2'd2;
    localparam logic [1:0] KIND_FRAME  = 2'd3;

    // header field ids
    localparam logic [2:0] HF_START     = 3'd0;
    localparam logic [2:0] HF_FRAMES    = 3'd1;
    localparam logic [2:0] HF_COMMENT   = 3'd2;
    localparam logic [2:0] HF_LINECMT   = 3'd3;
    localparam logic [2:0] HF_PLAYTIME  = 3'd4;
    localparam logic [2:0] HF_MODEL     = 3'd5;
    localparam logic [2:0] HF_MOTORS    = 3'd6;

    // frame field ids
    localparam logic [2:0] FF_ENABLE  = 3'd0;
    localparam logic [2:0] FF_TIME    = 3'd1;
    localparam logic [2:0] FF_DELAY   = 3'd2;
    localparam logic [2:0] FF_GROUP   = 3'd3;
    localparam logic [2:0] FF_COMMAND = 3'd4;
    localparam logic [2:0] FF_DATA0   = 3'd5;
    localparam logic [2:0] FF_DATA1   = 3'd6;

    // header layout
    localparam int OFF_W         = 10;
    localparam logic [OFF_W-1:0] MAGIC_END   = 10'd3;
    localparam logic [OFF_W-1:0] VERSION_END = 10'd6;
    localparam logic [OFF_W-1:0] NAME_END    = 10'd27;
    localparam logic [OFF_W-1:0] HDR_LAST    = 10'd40;

    // trailer offset of the last pad byte in a frame
    localparam logic [OFF_W-1:0] TRAILER_LAST = 10'd33;

    // axis word decode
    localparam logic [11:0] AXIS_DISABLED = 12'h7ff;

    localparam logic [7:0] MAGIC_LO [3] = '{8'h64, 8'h6d, 8'h74};
    localparam logic [7:0] MAGIC_UP [3] = '{8'h44, 8'h4d, 8'h54};
    localparam logic [7:0] VERSION  [3] = '{8'h31, 8'h2e, 8'h30};

    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         field_id;
        logic [15:0]        frame_number;
        logic [7:0]         axis_number;
        logic signed [31:0] value;
        logic [2:0]         led_code;
        logic               axis_type;
        logic               axis_enable;
    } result_t;

endpackage
`default_nettype wire

### rtl/motion_file_stream_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// motion_file_stream_parser
// Decodes a robot motion file byte by byte into header, axis and frame items.
// ----------------------------------------------------------------------------
// A completed result is registered into the result or the skid register.
// Throughput: one byte per cycle unless stalled; parser state updates on accept.
// A result register plus one skid register decouple the two sides, so input
// stalls only when both hold results that the sink has not taken.
// Reset (rst_n low, asynchronous): header phase, offset 0, counters cleared.
module motion_file_stream_parser
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire logic [7:0]         data_byte,
    input  wire logic               start_of_file,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [1:0]              kind,
    output logic [2:0]              field_id,
    output logic [15:0]             frame_number,
    output logic [7:0]              axis_number,
    output logic signed [31:0]      value,
    output logic [2:0]              led_code,
    output logic                    axis_type,
    output logic                    axis_enable
);
    import mfsp_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_FRAME  = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    phase_t           phase_reg, phase_next, cur_phase;
    logic [OFF_W-1:0] byte_offset_reg, byte_offset_next, cur_off;
    logic [15:0]      frame_counter_reg, frame_counter_next, cur_frame;
    logic [7:0]       axis_counter_reg, axis_counter_next, cur_axis;
    logic [15:0]      frame_total_reg, frame_total_next, cur_ftotal;
    logic [7:0]       motor_total_reg, motor_total_next, cur_motor;
    logic [1:0]       magic_case_ok_reg, magic_case_ok_next, cur_magic;
    logic [23:0]      partial_reg, partial_next, cur_partial;

    result_t          res;
    logic             res_valid;
    result_t          out_reg, skid_reg;
    logic             out_valid_reg, skid_valid_reg;

    logic             accept;
    logic             drain;
    logic [1:0]       magic_idx;
    logic [1:0]       ver_idx;
    logic [8:0]       axes_end;
    logic [OFF_W-1:0] trail;
    logic [15:0]      word;
    logic [15:0]      frame_inc;

    assign accept     = item_valid & ~item_stall;
    assign drain      = out_valid_reg & ~result_stall;
    assign item_stall = skid_valid_reg;

    // state seen by this byte: a start restarts the parser first
    always_comb
    begin
        if (start_of_file)
        begin
            cur_phase   = PH_HEADER;
            cur_off     = '0;
            cur_frame   = '0;
            cur_axis    = '0;
            cur_ftotal  = '0;
            cur_motor   = '0;
            cur_magic   = 2'b11;
            cur_partial = '0;
        end
        else
        begin
            cur_phase   = phase_reg;
            cur_off     = byte_offset_reg;
            cur_frame   = frame_counter_reg;
            cur_axis    = axis_counter_reg;
            cur_ftotal  = frame_total_reg;
            cur_motor   = motor_total_reg;
            cur_magic   = magic_case_ok_reg;
            cur_partial = partial_reg;
        end
    end

    // byte decode and next state
    assign magic_idx = cur_off[1:0];
    assign ver_idx   = cur_off[1:0] - 2'd3;
    assign axes_end  = {cur_motor, 1'b0};
    assign trail     = cur_off - {1'b0, axes_end} - 10'd1;
    assign word      = {data_byte, cur_partial[7:0]};
    assign frame_inc = cur_frame + 16'd1;

    always_comb
    begin
        phase_next         = cur_phase;
        byte_offset_next   = cur_off + 10'd1;
        frame_counter_next = cur_frame;
        axis_counter_next  = cur_axis;
        frame_total_next   = cur_ftotal;
        motor_total_next   = cur_motor;
        magic_case_ok_next = cur_magic;
        partial_next       = cur_partial;
        res                = '0;
        res_valid          = 1'b0;

        case (cur_phase)
            PH_HEADER:
            begin
                if (cur_off < MAGIC_END)
                begin
                    // magic, either case
                    if (data_byte != MAGIC_LO[magic_idx])
                        magic_case_ok_next[0] = 1'b0;
                    if (data_byte != MAGIC_UP[magic_idx])
                        magic_case_ok_next[1] = 1'b0;
                    if (magic_case_ok_next == 2'b00)
                    begin
                        res.kind   = KIND_REJECT;
                        res_valid  = 1'b1;
                        phase_next = PH_DONE;
                    end
                end
                else if (cur_off < VERSION_END)
                begin
                    // only version 1.0 is accepted
                    if (data_byte != VERSION[ver_idx])
                    begin
                        res.kind   = KIND_REJECT;
                        res_valid  = 1'b1;
                        phase_next = PH_DONE;
                    end
                end
                else if (cur_off >= NAME_END)
                begin
                    res.kind = KIND_HEADER;
                    case (cur_off)
                        10'd27:
                        begin
                            res.field_id = HF_START;
                            res.value    = $signed({24'd0, data_byte});
                            res_valid    = 1'b1;
                        end
                        10'd28, 10'd30, 10'd32, 10'd34, 10'd38:
                            partial_next = {16'd0, data_byte};
                        10'd35:
                            partial_next = {cur_partial[23:16], data_byte, cur_partial[7:0]};
                        10'd36:
                            partial_next = {data_byte, cur_partial[15:0]};
                        10'd29:
                        begin
                            frame_total_next = word;
                            res.field_id     = HF_FRAMES;
                            res.value        = $signed({16'd0, word});
                            res_valid        = 1'b1;
                        end
                        10'd31:
                        begin
                            res.field_id = HF_COMMENT;
                            res.value    = $signed({16'd0, word});
                            res_valid    = 1'b1;
                        end
                        10'd33:
                        begin
                            res.field_id = HF_LINECMT;
                            res.value    = $signed({16'd0, word});
                            res_valid    = 1'b1;
                        end
                        10'd37:
                        begin
                            res.field_id = HF_PLAYTIME;
                            res.value    = $signed({data_byte, cur_partial});
                            res_valid    = 1'b1;
                        end
                        10'd39:
                        begin
                            res.field_id = HF_MODEL;
                            res.value    = $signed({16'd0, word});
                            res_valid    = 1'b1;
                        end
                        default:
                        begin
                            // motor count closes the header
                            motor_total_next   = data_byte;
                            res.field_id       = HF_MOTORS;
                            res.value          = $signed({24'd0, data_byte});
                            res_valid          = 1'b1;
                            byte_offset_next   = '0;
                            axis_counter_next  = '0;
                            frame_counter_next = '0;
                            phase_next = (cur_ftotal != 16'd0) ? PH_FRAME : PH_DONE;
                        end
                    endcase
                end
            end

            PH_FRAME:
            begin
                res.frame_number = cur_frame;
                if (cur_off == '0)
                begin
                    // enable bit opens the frame
                    axis_counter_next = '0;
                    res.kind          = KIND_FRAME;
                    res.field_id      = FF_ENABLE;
                    res.value         = $signed({31'd0, data_byte[0]});
                    res_valid         = 1'b1;
                end
                else if (cur_off <= {1'b0, axes_end})
                begin
                    // axis words, low byte first
                    if (cur_off[0])
                    begin
                        partial_next = {16'd0, data_byte};
                    end
                    else
                    begin
                        res.kind        = KIND_AXIS;
                        res.axis_number = cur_axis;
                        res.led_code    = word[14:12];
                        res.axis_type   = word[15];
                        res.axis_enable = (word[11:0] != AXIS_DISABLED);
                        res.value       = res.axis_enable ?
                                          $signed({{20{word[11]}}, word[11:0]}) : '0;
                        res_valid       = 1'b1;
                        axis_counter_next = cur_axis + 8'd1;
                    end
                end
                else
                begin
                    // trailer fields and pad bytes
                    res.kind = KIND_FRAME;
                    case (trail)
                        10'd0, 10'd2, 10'd6, 10'd8:
                            partial_next = {16'd0, data_byte};
                        10'd1:
                        begin
                            res.field_id = FF_TIME;
                            res.value    = $signed({{16{word[15]}}, word});
                            res_valid    = 1'b1;
                        end
                        10'd3:
                        begin
                            res.field_id = FF_DELAY;
                            res.value    = $signed({{16{word[15]}}, word});
                            res_valid    = 1'b1;
                        end
                        10'd4:
                        begin
                            res.field_id = FF_GROUP;
                            res.value    = $signed({24'd0, data_byte});
                            res_valid    = 1'b1;
                        end
                        10'd5:
                        begin
                            res.field_id = FF_COMMAND;
                            res.value    = $signed({24'd0, data_byte});
                            res_valid    = 1'b1;
                        end
                        10'd7:
                        begin
                            res.field_id = FF_DATA0;
                            res.value    = $signed({{16{word[15]}}, word});
                            res_valid    = 1'b1;
                        end
                        10'd9:
                        begin
                            res.field_id = FF_DATA1;
                            res.value    = $signed({{16{word[15]}}, word});
                            res_valid    = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (trail >= TRAILER_LAST)
                    begin
                        byte_offset_next   = '0;
                        axis_counter_next  = '0;
                        frame_counter_next = frame_inc;
                        if (frame_inc >= cur_ftotal)
                            phase_next = PH_DONE;
                    end
                end
            end

            default:
            begin
                // done phase: bytes are dropped, state holds
                byte_offset_next = cur_off;
            end
        endcase
    end

    // parser state, result register and skid register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HEADER;
            byte_offset_reg   <= '0;
            frame_counter_reg <= '0;
            axis_counter_reg  <= '0;
            frame_total_reg   <= '0;
            motor_total_reg   <= '0;
            magic_case_ok_reg <= 2'b11;
            partial_reg       <= '0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
            out_reg           <= '0;
            skid_reg          <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg         <= phase_next;
                byte_offset_reg   <= byte_offset_next;
                frame_counter_reg <= frame_counter_next;
                axis_counter_reg  <= axis_counter_next;
                frame_total_reg   <= frame_total_next;
                motor_total_reg   <= motor_total_next;
                magic_case_ok_reg <= magic_case_ok_next;
                partial_reg       <= partial_next;
            end

            if (accept && res_valid)
            begin
                if (out_valid_reg && !drain)
                begin
                    skid_reg       <= res;
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_reg       <= res;
                    out_valid_reg <= 1'b1;
                end
            end
            else if (drain)
            begin
                if (skid_valid_reg)
                begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    // result ports
    assign result_valid = out_valid_reg;
    assign kind         = out_reg.kind;
    assign field_id     = out_reg.field_id;
    assign frame_number = out_reg.frame_number;
    assign axis_number  = out_reg.axis_number;
    assign value        = out_reg.value;
    assign led_code     = out_reg.led_code;
    assign axis_type    = out_reg.axis_type;
    assign axis_enable  = out_reg.axis_enable;

`ifndef ASSERT_OFF
    // skid only fills behind a held result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result with the output register empty");

    // done phase produces nothing until a new start
    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !start_of_file && phase_reg == PH_DONE) |-> !res_valid)
        else $error("result produced in done phase");

    // axis index stays within the motor count
    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == KIND_AXIS) |-> (cur_axis < cur_motor))
        else $error("axis index beyond motor count");

    // frame phase only with frames to parse
    a_frame_total: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FRAME) |-> (frame_total_reg != 16'd0))
        else $error("frame phase with zero frame total");

    // header offset never runs past the motor count byte
    a_header_off: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HEADER) |-> (byte_offset_reg <= HDR_LAST))
        else $error("header offset out of range");
`endif

endmodule
`default_nettype wire
